[rtl/core/crc8fc_pkg.sv]
// shared types, constants and functions of the crc-8 framed command checker
`timescale 1ns / 1ps

package crc8fc_pkg;

  localparam int unsigned CountW   = 17;
  localparam int unsigned AddrW    = 4;
  localparam int unsigned DataW    = 32;

  localparam logic [7:0]        CrcPoly  = 8'h8C;
  localparam logic [7:0]        CrcInit  = 8'h42;
  localparam logic [CountW-1:0] CountMax = 17'h1FFFF;
  localparam logic [15:0]       LenLoMask = 16'h00FF;

  // byte positions within a frame
  localparam logic [CountW-1:0] PosStart1 = 17'd0;
  localparam logic [CountW-1:0] PosStart2 = 17'd1;
  localparam logic [CountW-1:0] PosStart3 = 17'd2;
  localparam logic [CountW-1:0] PosLenHi  = 17'd3;
  localparam logic [CountW-1:0] PosLenLo  = 17'd4;
  localparam logic [CountW-1:0] PosFunc   = 17'd5;

  // register indexes
  localparam logic [1:0] RegStart1  = 2'd0;
  localparam logic [1:0] RegStart2  = 2'd1;
  localparam logic [1:0] RegStart3  = 2'd2;
  localparam logic [1:0] RegChannel = 2'd3;

  // function codes
  localparam logic [7:0] FuncZero  = 8'h00;
  localparam logic [7:0] FuncOne   = 8'h01;
  localparam logic [7:0] FuncTwo   = 8'h02;
  localparam logic [7:0] FuncThree = 8'h03;

  // channel kinds
  localparam logic ChanDatagram = 1'b0;

  // frame kinds
  localparam logic [2:0] KindNone      = 3'd0;
  localparam logic [2:0] KindSearch    = 3'd1;
  localparam logic [2:0] KindCubeSet   = 3'd2;
  localparam logic [2:0] KindReset     = 3'd3;
  localparam logic [2:0] KindAnimStart = 3'd4;
  localparam logic [2:0] KindAnimStop  = 3'd5;

  typedef struct packed {
    logic [7:0] start_byte_one;
    logic [7:0] start_byte_two;
    logic [7:0] start_byte_three;
    logic       channel_kind;
  } cfg_t;

  // reflected crc-8, one byte, unrolled over its eight bits
  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  function automatic logic [2:0] classify(input logic chan, input logic [7:0] func);
    logic [2:0] kind;
    kind = KindNone;
    if (chan == ChanDatagram) begin
      priority if (func == FuncZero) kind = KindSearch;
      else if (func == FuncOne)      kind = KindCubeSet;
      else if (func == FuncTwo)      kind = KindReset;
      else                           kind = KindNone;
    end else begin
      priority if (func == FuncOne) kind = KindCubeSet;
      else if (func == FuncTwo)     kind = KindAnimStart;
      else if (func == FuncThree)   kind = KindAnimStop;
      else                          kind = KindNone;
    end
    return kind;
  endfunction

endpackage

[rtl/core/crc8fc_if.sv]
// valid/ready channel interfaces for frame bytes and frame results
`timescale 1ns / 1ps

interface crc8fc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_value;
  logic       last_byte;

  modport source (output valid, output byte_value, output last_byte, input ready);
  modport sink   (input valid, input byte_value, input last_byte, output ready);
endinterface

interface crc8fc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] frame_kind;

  modport source (output valid, output frame_kind, input ready);
  modport sink   (input valid, input frame_kind, output ready);
endinterface

[rtl/core/crc8fc_cfg_regs.sv]
// apb-style configuration registers
`timescale 1ns / 1ps

module crc8fc_cfg_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [crc8fc_pkg::AddrW-1:0] cfg_paddr,
  input  logic [crc8fc_pkg::DataW-1:0] cfg_pwdata,
  output logic [crc8fc_pkg::DataW-1:0] cfg_prdata,
  output logic                        cfg_pready,
  output crc8fc_pkg::cfg_t            cfg
);

  crc8fc_pkg::cfg_t cfg_r;
  logic             wr_en;
  logic [1:0]       reg_idx;

  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite;
  assign reg_idx    = cfg_paddr[3:2];
  assign cfg        = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (reg_idx)
        crc8fc_pkg::RegStart1:  cfg_r.start_byte_one   <= cfg_pwdata[7:0];
        crc8fc_pkg::RegStart2:  cfg_r.start_byte_two   <= cfg_pwdata[7:0];
        crc8fc_pkg::RegStart3:  cfg_r.start_byte_three <= cfg_pwdata[7:0];
        crc8fc_pkg::RegChannel: cfg_r.channel_kind     <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      crc8fc_pkg::RegStart1:  cfg_prdata = {24'd0, cfg_r.start_byte_one};
      crc8fc_pkg::RegStart2:  cfg_prdata = {24'd0, cfg_r.start_byte_two};
      crc8fc_pkg::RegStart3:  cfg_prdata = {24'd0, cfg_r.start_byte_three};
      crc8fc_pkg::RegChannel: cfg_prdata = {31'd0, cfg_r.channel_kind};
      default:                cfg_prdata = '0;
    endcase
  end

endmodule

[rtl/core/crc8fc_frame_tracker.sv]
// per-frame state: byte count, running crc, header capture and final check
`timescale 1ns / 1ps

module crc8fc_frame_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  crc8fc_pkg::cfg_t cfg,
  input  logic             step,
  input  logic [7:0]       byte_value,
  input  logic             last_byte,
  output logic [2:0]       frame_kind
);

  logic [crc8fc_pkg::CountW-1:0] count_r, count_nxt;
  logic [7:0]                    crc_r, crc_nxt;
  logic                          hdr_ok_r, hdr_ok_nxt;
  logic [15:0]                   len_r, len_nxt;
  logic [7:0]                    func_r, func_nxt;
  logic [crc8fc_pkg::CountW-1:0] count_inc;
  logic                          frame_ok;

  assign count_inc = count_r + 1'b1;

  assign frame_ok = (count_r >= crc8fc_pkg::PosFunc) && (count_r < crc8fc_pkg::CountMax) &&
                    hdr_ok_r && (byte_value == crc_r) &&
                    ({1'b0, len_r} == count_inc);

  always_comb begin
    frame_kind = crc8fc_pkg::KindNone;
    if (last_byte && frame_ok) begin
      // six-byte frame: the last byte doubles as the function byte
      frame_kind = crc8fc_pkg::classify(cfg.channel_kind,
                     (count_r == crc8fc_pkg::PosFunc) ? byte_value : func_r);
    end
  end

  always_comb begin
    count_nxt  = count_r;
    crc_nxt    = crc_r;
    hdr_ok_nxt = hdr_ok_r;
    len_nxt    = len_r;
    func_nxt   = func_r;
    if (step) begin
      if (last_byte) begin
        count_nxt  = '0;
        crc_nxt    = crc8fc_pkg::CrcInit;
        hdr_ok_nxt = 1'b1;
        len_nxt    = '0;
        func_nxt   = '0;
      end else begin
        if (count_r == crc8fc_pkg::PosStart1 && byte_value != cfg.start_byte_one)
          hdr_ok_nxt = 1'b0;
        if (count_r == crc8fc_pkg::PosStart2 && byte_value != cfg.start_byte_two)
          hdr_ok_nxt = 1'b0;
        if (count_r == crc8fc_pkg::PosStart3 && byte_value != cfg.start_byte_three)
          hdr_ok_nxt = 1'b0;
        if (count_r == crc8fc_pkg::PosLenHi)
          len_nxt = (len_r & crc8fc_pkg::LenLoMask) | {byte_value, 8'd0};
        if (count_r == crc8fc_pkg::PosLenLo)
          len_nxt = (len_r & ~crc8fc_pkg::LenLoMask) | {8'd0, byte_value};
        if (count_r == crc8fc_pkg::PosFunc)
          func_nxt = byte_value;
        crc_nxt = crc8fc_pkg::crc_next(crc_r, byte_value);
        if (count_r < crc8fc_pkg::CountMax)
          count_nxt = count_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r  <= '0;
      crc_r    <= crc8fc_pkg::CrcInit;
      hdr_ok_r <= 1'b1;
      len_r    <= '0;
      func_r   <= '0;
    end else begin
      count_r  <= count_nxt;
      crc_r    <= crc_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      len_r    <= len_nxt;
      func_r   <= func_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (step && last_byte) |=> (count_r == '0 && crc_r == crc8fc_pkg::CrcInit && hdr_ok_r))
    else $error("frame state not cleared after last item");
  a_count_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    (step && !last_byte) |=> (count_r >= $past(count_r)))
    else $error("byte count went backwards inside a frame");
  a_kind_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (frame_kind != crc8fc_pkg::KindNone) |-> (last_byte && hdr_ok_r))
    else $error("frame kind set without a checked last byte");
`endif

endmodule

[rtl/core/crc8_framed_command_checker.sv]
// top level of the crc-8 framed command checker
// usage:
//   in_ch carries one frame byte per item, with last_byte set on the final
//   (crc) byte. out_ch carries one frame_kind item per frame, issued for the
//   last byte only; other bytes give no result.
//   cfg_* is an apb-style port: start bytes at 0x0, 0x4, 0x8 and the function
//   table select at 0xc. write only while the block is idle; pready is tied high.
// timing:
//   each accepted byte is held in the input register, where the crc, header
//   and length logic runs; for a last byte the result is registered in the
//   output register, which drives out_ch.valid and out_ch.frame_kind.
//   one byte per cycle sustained while no last byte is held back (see stall);
//   the unrolled crc update is combinational.
// reset:
//   synchronous active-low rst_n clears both stages, the frame state and the
//   registers; a frame in progress is dropped.
// stall:
//   while a result waits in the output register, non-last bytes keep flowing;
//   a following last byte holds in the input register, and in_ch.ready drops
//   only then, until out_ch.ready takes the waiting result.
`timescale 1ns / 1ps

module crc8_framed_command_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  crc8fc_in_if.sink                    in_ch,
  crc8fc_out_if.source                 out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [crc8fc_pkg::AddrW-1:0] cfg_paddr,
  input  logic [crc8fc_pkg::DataW-1:0] cfg_pwdata,
  output logic [crc8fc_pkg::DataW-1:0] cfg_prdata,
  output logic                         cfg_pready
);

  crc8fc_pkg::cfg_t cfg;

  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_last_r;
  logic       out_valid_r, out_valid_nxt;
  logic [2:0] out_kind_r;
  logic       in_fire, slot_free, s1_adv;
  logic [2:0] kind;

  crc8fc_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  crc8fc_frame_tracker u_track (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .step       (s1_adv),
    .byte_value (s1_byte_r),
    .last_byte  (s1_last_r),
    .frame_kind (kind)
  );

  // non-last bytes never need the output slot
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign s1_adv      = s1_valid_r && (!s1_last_r || slot_free);
  assign in_ch.ready = !s1_valid_r || s1_adv;
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid      = out_valid_r;
  assign out_ch.frame_kind = out_kind_r;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_adv && s1_last_r) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r <= in_ch.byte_value;
      s1_last_r <= in_ch.last_byte;
    end
    if (s1_adv && s1_last_r) begin
      out_kind_r <= kind;
    end
  end

`ifndef ASSERT_OFF
  a_reset_clears_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r)
    else $error("result valid after reset");
  a_ready_low_only_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && s1_last_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a blocked last item");
  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r && !out_ch.ready)) |-> $past(s1_adv && s1_last_r))
    else $error("result appeared without a last item");
  a_no_result_for_body: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && !s1_last_r && !out_valid_r) |=> !out_valid_r)
    else $error("non-last item produced a result");
`endif

endmodule

[verif/tb_top.sv]
// testbench for the crc-8 framed command checker: directed frames, then random framed traffic
`timescale 1ns / 1ps

module tb_top;

  localparam int unsigned CycleLimit  = 200_000;
  localparam int unsigned RandomBytes = 1100;
  localparam int unsigned DrainCycles = 20;
  localparam int unsigned PhaseCount  = 5;
  localparam logic        ChanStream  = ~crc8fc_pkg::ChanDatagram;

  typedef enum logic [3:0] {
    FrmGood, FrmBadCrc, FrmBadStart1, FrmBadStart2, FrmBadStart3,
    FrmBadLen, FrmShort, FrmNoise
  } frame_shape_t;

  typedef struct {
    crc8fc_pkg::cfg_t cfg;
    frame_shape_t     shape;
    int unsigned      len;
    logic [7:0]       func;
    bit               typed;
    logic [2:0]       kind;
  } frame_row_t;

  logic                         clk;
  logic                         rst_n;
  logic                         cfg_psel;
  logic                         cfg_penable;
  logic                         cfg_pwrite;
  logic [crc8fc_pkg::AddrW-1:0] cfg_paddr;
  logic [crc8fc_pkg::DataW-1:0] cfg_pwdata;
  logic [crc8fc_pkg::DataW-1:0] cfg_prdata;
  logic                         cfg_pready;

  crc8fc_in_if  in_if ();
  crc8fc_out_if out_if ();

  crc8_framed_command_checker uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_if),
    .out_ch      (out_if),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // frame tracker state, mirrors the block
  crc8fc_pkg::cfg_t              model_cfg;
  logic [crc8fc_pkg::CountW-1:0] rx_count;
  logic [7:0]                    rx_crc;
  logic                          rx_hdr_ok;
  logic [15:0]                   rx_len;
  logic [7:0]                    rx_func;

  logic [2:0]  pending_kinds[$];
  logic [7:0]  frame_bytes[$];
  bit          use_typed = 1'b0;
  logic [2:0]  typed_kind = crc8fc_pkg::KindNone;
  bit          idle_on = 1'b0;
  bit          stall_on = 1'b0;
  int unsigned errors = 0;
  int unsigned cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("[crc8_framed_command_checker] ERROR");
      $finish;
    end
  end

  function automatic logic [7:0] crc8_step(logic [7:0] crc, logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = r[0] ? ((r >> 1) ^ crc8fc_pkg::CrcPoly) : (r >> 1);
    return r;
  endfunction

  function automatic logic [2:0] kind_of_func(logic chan, logic [7:0] f);
    if (chan == crc8fc_pkg::ChanDatagram) begin
      unique case (f)
        crc8fc_pkg::FuncZero: return crc8fc_pkg::KindSearch;
        crc8fc_pkg::FuncOne:  return crc8fc_pkg::KindCubeSet;
        crc8fc_pkg::FuncTwo:  return crc8fc_pkg::KindReset;
        default:              return crc8fc_pkg::KindNone;
      endcase
    end else begin
      unique case (f)
        crc8fc_pkg::FuncOne:   return crc8fc_pkg::KindCubeSet;
        crc8fc_pkg::FuncTwo:   return crc8fc_pkg::KindAnimStart;
        crc8fc_pkg::FuncThree: return crc8fc_pkg::KindAnimStop;
        default:               return crc8fc_pkg::KindNone;
      endcase
    end
  endfunction

  function automatic void clear_frame();
    rx_count  = '0;
    rx_crc    = crc8fc_pkg::CrcInit;
    rx_hdr_ok = 1'b1;
    rx_len    = '0;
    rx_func   = '0;
  endfunction

  // update the tracker with one accepted item, queue the frame kind on a last byte
  function automatic void track_byte(logic [7:0] b, logic last);
    logic [2:0] kind;
    kind = crc8fc_pkg::KindNone;
    if (!last) begin
      unique case (rx_count)
        crc8fc_pkg::PosStart1:
          if (b != model_cfg.start_byte_one) rx_hdr_ok = 1'b0;
        crc8fc_pkg::PosStart2:
          if (b != model_cfg.start_byte_two) rx_hdr_ok = 1'b0;
        crc8fc_pkg::PosStart3:
          if (b != model_cfg.start_byte_three) rx_hdr_ok = 1'b0;
        crc8fc_pkg::PosLenHi: rx_len[15:8] = b;
        crc8fc_pkg::PosLenLo: rx_len[7:0] = b;
        crc8fc_pkg::PosFunc:  rx_func = b;
        default: ;
      endcase
      rx_crc = crc8_step(rx_crc, b);
      if (rx_count != crc8fc_pkg::CountMax) rx_count = rx_count + 1'b1;
    end else begin
      // on a six-byte frame the crc byte doubles as the function byte
      if (rx_count >= crc8fc_pkg::PosFunc && rx_count != crc8fc_pkg::CountMax &&
          rx_hdr_ok && b == rx_crc && {1'b0, rx_len} == rx_count + 1'b1) begin
        kind = kind_of_func(model_cfg.channel_kind,
                            (rx_count == crc8fc_pkg::PosFunc) ? b : rx_func);
      end
      pending_kinds.push_back(use_typed ? typed_kind : kind);
      clear_frame();
    end
  endfunction

  function automatic void build_frame(crc8fc_pkg::cfg_t c, frame_shape_t shape,
                                      int unsigned len, logic [7:0] func);
    logic [7:0]  crc;
    logic [15:0] lenf;
    int unsigned body;
    frame_bytes.delete();
    if (shape == FrmNoise) begin
      repeat (len) frame_bytes.push_back(8'($urandom_range(0, 255)));
      return;
    end
    lenf = (shape == FrmBadLen) ? len[15:0] + 16'd1 : len[15:0];
    frame_bytes = '{c.start_byte_one, c.start_byte_two, c.start_byte_three,
                    lenf[15:8], lenf[7:0], func};
    case (shape)
      FrmBadStart1: frame_bytes[0] = frame_bytes[0] ^ 8'($urandom_range(1, 255));
      FrmBadStart2: frame_bytes[1] = frame_bytes[1] ^ 8'($urandom_range(1, 255));
      FrmBadStart3: frame_bytes[2] = frame_bytes[2] ^ 8'($urandom_range(1, 255));
      default: ;
    endcase
    body = len - 1;
    while (frame_bytes.size() < body) frame_bytes.push_back(8'($urandom_range(0, 255)));
    while (frame_bytes.size() > body) void'(frame_bytes.pop_back());
    crc = crc8fc_pkg::CrcInit;
    foreach (frame_bytes[i]) crc = crc8_step(crc, frame_bytes[i]);
    if (shape == FrmBadCrc) crc = crc ^ (8'd1 << $urandom_range(0, 7));
    frame_bytes.push_back(crc);
  endfunction

  task automatic send_byte(logic [7:0] b, logic last);
    int unsigned gap;
    bit hit;
    if (idle_on && $urandom_range(0, 9) == 0) begin
      gap = $urandom_range(1, 16);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid      <= 1'b1;
    in_if.byte_value <= b;
    in_if.last_byte  <= last;
    do begin
      @(negedge clk);
      hit = in_if.ready;
      @(posedge clk);
    end while (!hit);
    track_byte(b, last);
  endtask

  task automatic send_frame();
    foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
  endtask

  task automatic wait_drain();
    in_if.valid <= 1'b0;
    while (pending_kinds.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // apb write then read back
  task automatic set_reg(string name, logic [1:0] idx, logic [crc8fc_pkg::DataW-1:0] value);
    logic [crc8fc_pkg::DataW-1:0] got;
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    got = cfg_prdata;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== value) begin
      $error("%s: expected 0x%0h, actual 0x%0h", name, value, got);
      errors++;
    end
  endtask

  task automatic load_config(crc8fc_pkg::cfg_t c);
    set_reg("start_byte_one", crc8fc_pkg::RegStart1, c.start_byte_one);
    set_reg("start_byte_two", crc8fc_pkg::RegStart2, c.start_byte_two);
    set_reg("start_byte_three", crc8fc_pkg::RegStart3, c.start_byte_three);
    set_reg("channel_kind", crc8fc_pkg::RegChannel, c.channel_kind);
    model_cfg = c;
  endtask

  function automatic frame_row_t mk_row(crc8fc_pkg::cfg_t c, frame_shape_t s, int unsigned len,
                                        logic [7:0] f, bit typed, logic [2:0] k);
    frame_row_t r;
    r.cfg   = c;
    r.shape = s;
    r.len   = len;
    r.func  = f;
    r.typed = typed;
    r.kind  = k;
    return r;
  endfunction

  always @(negedge clk) begin : result_check
    logic [2:0] want;
    if (rst_n && out_if.valid && out_if.ready) begin
      if (pending_kinds.size() == 0) begin
        $error("frame_kind: expected none, actual %0d", out_if.frame_kind);
        errors++;
      end else begin
        want = pending_kinds.pop_front();
        if (out_if.frame_kind !== want) begin
          $error("frame_kind: expected %0d, actual %0d", want, out_if.frame_kind);
          errors++;
        end
      end
    end
  end

  initial begin : result_ready
    int unsigned gap;
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_on && $urandom_range(0, 7) == 0) begin
        gap = $urandom_range(1, 16);
        out_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_if.ready <= 1'b1;
    end
  end

  initial begin : stimulus
    crc8fc_pkg::cfg_t cfg_zero;
    crc8fc_pkg::cfg_t cfg_high;
    crc8fc_pkg::cfg_t cfg_mixed;
    crc8fc_pkg::cfg_t c;
    frame_row_t       rows[$];
    frame_shape_t     faults[7];
    frame_shape_t     shape;
    int unsigned      sent;
    int unsigned      len;
    int unsigned      frames;
    logic [7:0]       func;

    cfg_zero  = '0;
    cfg_high  = '{8'hFF, 8'hFF, 8'hFF, ChanStream};
    cfg_mixed = '{8'h5A, 8'hA5, 8'h3C, crc8fc_pkg::ChanDatagram};
    faults    = '{FrmBadCrc, FrmBadStart1, FrmBadStart2, FrmBadStart3,
                  FrmBadLen, FrmShort, FrmNoise};

    rst_n            = 1'b0;
    in_if.valid      = 1'b0;
    in_if.byte_value = '0;
    in_if.last_byte  = 1'b0;
    cfg_psel         = 1'b0;
    cfg_penable      = 1'b0;
    cfg_pwrite       = 1'b0;
    cfg_paddr        = '0;
    cfg_pwdata       = '0;
    model_cfg        = '0;
    clear_frame();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    //                    cfg        shape         len  func                    typed kind
    rows.push_back(mk_row(cfg_zero,  FrmGood,      7,   crc8fc_pkg::FuncZero,  1,
                          crc8fc_pkg::KindSearch));
    rows.push_back(mk_row(cfg_zero,  FrmGood,      7,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindCubeSet));
    rows.push_back(mk_row(cfg_zero,  FrmGood,      9,   crc8fc_pkg::FuncTwo,   1,
                          crc8fc_pkg::KindReset));
    rows.push_back(mk_row(cfg_zero,  FrmGood,      7,   crc8fc_pkg::FuncThree, 1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmGood,      8,   8'hFF,                 1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmBadCrc,    7,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmBadStart1, 7,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmBadStart2, 7,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmBadStart3, 7,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmBadLen,    7,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmShort,     1,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmShort,     5,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmGood,      6,   crc8fc_pkg::FuncOne,   0,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_zero,  FrmGood,      258, crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindCubeSet));
    rows.push_back(mk_row(cfg_high,  FrmGood,      7,   crc8fc_pkg::FuncOne,   1,
                          crc8fc_pkg::KindCubeSet));
    rows.push_back(mk_row(cfg_high,  FrmGood,      7,   crc8fc_pkg::FuncTwo,   1,
                          crc8fc_pkg::KindAnimStart));
    rows.push_back(mk_row(cfg_high,  FrmGood,      10,  crc8fc_pkg::FuncThree, 1,
                          crc8fc_pkg::KindAnimStop));
    rows.push_back(mk_row(cfg_high,  FrmGood,      7,   crc8fc_pkg::FuncZero,  1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_high,  FrmGood,      6,   crc8fc_pkg::FuncTwo,   0,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_high,  FrmGood,      12,  8'h80,                 0,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_mixed, FrmGood,      10,  crc8fc_pkg::FuncTwo,   1,
                          crc8fc_pkg::KindReset));
    rows.push_back(mk_row(cfg_mixed, FrmBadStart3, 8,   crc8fc_pkg::FuncZero,  1,
                          crc8fc_pkg::KindNone));
    rows.push_back(mk_row(cfg_mixed, FrmNoise,     9,   crc8fc_pkg::FuncZero,  0,
                          crc8fc_pkg::KindNone));

    idle_on  = 1'b1;
    stall_on = 1'b1;
    foreach (rows[i]) begin
      if (rows[i].cfg != model_cfg) begin
        wait_drain();
        load_config(rows[i].cfg);
      end
      use_typed  = rows[i].typed;
      typed_kind = rows[i].kind;
      build_frame(rows[i].cfg, rows[i].shape, rows[i].len, rows[i].func);
      send_frame();
    end
    use_typed = 1'b0;

    for (int unsigned phase = 0; phase < PhaseCount; phase++) begin
      c.start_byte_one   = 8'($urandom_range(0, 255));
      c.start_byte_two   = 8'($urandom_range(0, 255));
      c.start_byte_three = 8'($urandom_range(0, 255));
      c.channel_kind     = 1'($urandom_range(0, 1));
      if (phase == 1) c = '{8'h00, 8'h00, 8'h00, ChanStream};
      if (phase == 3) c = '{8'hFF, 8'hFF, 8'hFF, crc8fc_pkg::ChanDatagram};
      wait_drain();
      load_config(c);
      // last phase runs with no input gaps and the result side always ready
      idle_on  = phase != PhaseCount - 1;
      stall_on = idle_on;
      sent     = 0;
      frames   = 0;
      while (sent < RandomBytes / PhaseCount) begin
        shape = ($urandom_range(0, 99) < 70) ? FrmGood : faults[$urandom_range(0, 6)];
        case ($urandom_range(0, 19))
          0, 1:    len = 6;
          2:       len = $urandom_range(60, 300);
          default: len = $urandom_range(7, 24);
        endcase
        if (shape == FrmShort) len = $urandom_range(1, 5);
        if (shape == FrmNoise) len = $urandom_range(1, 12);
        func = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 3))
                                            : 8'($urandom_range(0, 255));
        build_frame(c, shape, len, func);
        send_frame();
        sent += frame_bytes.size();
        frames++;
        // every 25 frames, hold the sender until every frame kind has come back
        if (frames % 25 == 0) wait_drain();
      end
    end

    wait_drain();
    if (errors == 0) begin
      $display("[crc8_framed_command_checker] OK");
    end else begin
      $display("[crc8_framed_command_checker] ERROR");
    end
    $finish;
  end

endmodule
